### rtl/core/timer_table_scheduler_unit_assert.svh
// assertion macros shared by the timer table rtl
// depends on nothing
`ifndef TIMER_TABLE_SCHEDULER_UNIT_ASSERT_SVH
`define TIMER_TABLE_SCHEDULER_UNIT_ASSERT_SVH
// clocked assertion with asynchronous reset disable
`define TTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication form
`define TTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

### rtl/core/tts_pkg.sv
// package for the timer table: widths, opcodes, status codes, command structs
// used by the timer table modules except the generic tts_ram
`timescale 1ns / 1ps
package tts_pkg;
  localparam int unsigned TimerSlots = 16;
  localparam int unsigned SlotW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int unsigned CntW = $clog2(TimerSlots + 1);
  localparam int unsigned IdW = 32;
  localparam int unsigned DlyW = 31;
  localparam int unsigned TimeW = 48;

  localparam logic [2:0] OpSetOne = 3'd0;
  localparam logic [2:0] OpSetPer = 3'd1;
  localparam logic [2:0] OpClear = 3'd2;
  localparam logic [2:0] OpNext = 3'd3;
  localparam logic [2:0] OpFire = 3'd4;
  localparam logic [2:0] OpClrAll = 3'd5;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic scan_rd;    // read slot at scan index
    logic scan_eval;  // evaluate data read last cycle
    logic scan_rst;   // clear scan bookkeeping
    logic commit;     // apply result and write table
    logic out_take;   // output taken
  } tts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_valid;
  } tts_sts_t;

  // saturating wake time
  function automatic logic [TimeW-1:0] wake_add(input logic [TimeW-1:0] now,
                                                input logic [DlyW-1:0] dly);
    logic [TimeW:0] s;
    s = {1'b0, now} + {{(TimeW-DlyW+1){1'b0}}, dly};
    wake_add = s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction
endpackage

### rtl/core/timer_table_scheduler_unit.sv
// channel | handshake            | payload
// in      | in_valid / in_ready  | opcode_i delay_ms_i timer_id_i now_ms_i
// out     | out_valid / out_ready| status_o result_id_o due_ms_o is_periodic_o
// each item passes through a load step, a scan that reads one slot per cycle from the
// slot ram, and a commit step.
// reset clears valid bits and the id counter; slot contents need no clearing.
// a waiting result lets the next item load and scan, and holds it only in its commit.
// top level of the timer table; depends on tts_pkg, tts_ctrl, tts_dp
`timescale 1ns / 1ps
module timer_table_scheduler_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2:0]                opcode_i,
  input  logic [tts_pkg::DlyW-1:0]  delay_ms_i,
  input  logic [tts_pkg::IdW-1:0]   timer_id_i,
  input  logic [tts_pkg::TimeW-1:0] now_ms_i,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status_o,
  output logic [tts_pkg::IdW-1:0]   result_id_o,
  output logic [tts_pkg::TimeW-1:0] due_ms_o,
  output logic                      is_periodic_o
);
  import tts_pkg::*;
  tts_cmd_t cmd;
  tts_sts_t sts;

  // sequencer
  tts_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_ready, .cmd_o(cmd), .sts_i(sts)
  );

  // table datapath
  tts_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .opcode_i, .delay_ms_i, .timer_id_i, .now_ms_i,
    .status_o, .result_id_o, .due_ms_o, .is_periodic_o
  );

  assign out_valid = sts.out_valid;
endmodule

### rtl/core/tts_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// depends on nothing
`timescale 1ns / 1ps
module tts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### rtl/core/tts_ctrl.sv
// controller state machine of the timer table: sequences load, scan, commit
// depends on tts_pkg
`timescale 1ns / 1ps
module tts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output tts_pkg::tts_cmd_t cmd_o,
  input  tts_pkg::tts_sts_t sts_i
);
  import tts_pkg::*;
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SScan = 2'd1;
  localparam logic [1:0] SCommit = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // accept whenever idle; a pending result only holds the commit
  assign in_ready = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    cmd_o.out_take = sts_i.out_valid && out_ready;
    unique case (state_q)
      SIdle: begin
        if (in_valid && in_ready) begin
          cmd_o.load = 1'b1;
          cmd_o.scan_rst = 1'b1;
          cnt_d = '0;
          state_d = SScan;
        end
      end
      SScan: begin
        // read slot cnt, evaluate slot cnt-1
        cmd_o.scan_rd = (cnt_q < CntW'(TimerSlots));
        cmd_o.scan_eval = (cnt_q != '0);
        if (cnt_q == CntW'(TimerSlots)) state_d = SCommit;
        else cnt_d = cnt_q + 1'b1;
      end
      SCommit: begin
        // wait here while the previous result is still pending
        if (!sts_i.out_valid || out_ready) begin
          cmd_o.commit = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  `include "timer_table_scheduler_unit_assert.svh"
  `TTS_ASSERT_IMP(a_load_idle, clk_i, rst_ni, cmd_o.load, state_q == SIdle, "load outside idle")
  `TTS_ASSERT_IMP(a_scan_cnt, clk_i, rst_ni, state_q == SScan, cnt_q <= CntW'(TimerSlots), "scan overrun")
  `TTS_ASSERT_IMP(a_commit_next, clk_i, rst_ni, cmd_o.commit, ##1 state_q == SIdle, "commit not followed by idle")
endmodule

### rtl/core/tts_dp.sv
// datapath of the timer table: slot memories, scan, commit and output register
// depends on tts_pkg and tts_ram
`timescale 1ns / 1ps
module tts_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tts_pkg::tts_cmd_t         cmd_i,
  output tts_pkg::tts_sts_t         sts_o,
  input  logic [2:0]                opcode_i,
  input  logic [tts_pkg::DlyW-1:0]  delay_ms_i,
  input  logic [tts_pkg::IdW-1:0]   timer_id_i,
  input  logic [tts_pkg::TimeW-1:0] now_ms_i,
  output logic [1:0]                status_o,
  output logic [tts_pkg::IdW-1:0]   result_id_o,
  output logic [tts_pkg::TimeW-1:0] due_ms_o,
  output logic                      is_periodic_o
);
  import tts_pkg::*;
  localparam int unsigned EntW = IdW + 1 + DlyW + TimeW;

  logic [2:0] op_q;
  logic [DlyW-1:0] dly_q;
  logic [IdW-1:0] tid_q;
  logic [TimeW-1:0] now_q;
  logic [TimerSlots-1:0] valid_q, valid_d;
  logic [IdW-1:0] nid_q;
  logic [SlotW-1:0] rd_idx_q, ev_idx_q;
  logic [SlotW-1:0] raddr;
  logic [EntW-1:0] rdata, wdata;
  logic we;
  logic [SlotW-1:0] waddr;
  // scan bookkeeping
  logic hit_q, free_q;
  logic [SlotW-1:0] hit_idx_q, free_idx_q;
  logic [EntW-1:0] hit_ent_q;
  logic [IdW-1:0] r_id;
  logic r_per;
  logic [DlyW-1:0] r_dly;
  logic [TimeW-1:0] r_wake, h_wake;
  logic [IdW-1:0] h_id;
  logic h_per;
  logic [DlyW-1:0] h_dly;
  logic ev_valid, better;
  logic out_v_q;
  logic [1:0] st_q;
  logic [IdW-1:0] rid_q;
  logic [TimeW-1:0] due_q;
  logic per_q;

  assign raddr = rd_idx_q;
  assign {r_id, r_per, r_dly, r_wake} = rdata;
  assign {h_id, h_per, h_dly, h_wake} = hit_ent_q;

  tts_ram #(.Width(EntW), .Depth(TimerSlots)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  // per-slot compare of the entry read last cycle
  assign ev_valid = valid_q[ev_idx_q];
  always_comb begin
    better = 1'b0;
    if (op_q == OpNext) begin
      better = !hit_q || (r_wake < h_wake) || ((r_wake == h_wake) && (r_id < h_id));
    end else begin
      better = !hit_q && (r_id == tid_q);
    end
  end

  // item capture and scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      dly_q <= delay_ms_i;
      tid_q <= timer_id_i;
      now_q <= now_ms_i;
    end
    if (cmd_i.scan_eval && ev_valid && better) begin
      hit_ent_q <= rdata;
      hit_idx_q <= ev_idx_q;
    end
    if (cmd_i.scan_eval && !ev_valid && !free_q) free_idx_q <= ev_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q <= '0;
      ev_idx_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (cmd_i.scan_rst) begin
        rd_idx_q <= '0;
        hit_q <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          ev_idx_q <= rd_idx_q;
          rd_idx_q <= rd_idx_q + 1'b1;
        end
        if (cmd_i.scan_eval) begin
          if (ev_valid && better) hit_q <= 1'b1;
          if (!ev_valid) free_q <= 1'b1;
        end
      end
    end
  end

  // commit: table write and result
  logic [1:0] st_d;
  logic [IdW-1:0] rid_d;
  logic [TimeW-1:0] due_d, rewake;
  logic per_d;
  assign rewake = wake_add(now_q, h_dly);
  always_comb begin
    we = 1'b0;
    waddr = free_idx_q;
    wdata = {nid_q, op_q == OpSetPer, dly_q, wake_add(now_q, dly_q)};
    valid_d = valid_q;
    st_d = StOk; rid_d = '0; due_d = '0; per_d = 1'b0;
    unique case (op_q)
      OpSetOne, OpSetPer: begin
        if (!free_q) st_d = StFull;
        else begin
          we = 1'b1;
          valid_d[free_idx_q] = 1'b1;
          rid_d = nid_q; due_d = wake_add(now_q, dly_q); per_d = op_q == OpSetPer;
        end
      end
      OpClear: begin
        if (!hit_q) st_d = StNotFound;
        else begin
          valid_d[hit_idx_q] = 1'b0;
          rid_d = h_id; due_d = h_wake; per_d = h_per;
        end
      end
      OpNext: begin
        if (!hit_q) st_d = StEmpty;
        else begin
          rid_d = h_id; due_d = h_wake; per_d = h_per;
        end
      end
      OpFire: begin
        if (!hit_q) st_d = StNotFound;
        else begin
          rid_d = h_id; per_d = h_per;
          if (h_per) begin
            we = 1'b1; waddr = hit_idx_q;
            wdata = {h_id, 1'b1, h_dly, rewake};
            due_d = rewake;
          end else begin
            valid_d[hit_idx_q] = 1'b0;
            due_d = h_wake;
          end
        end
      end
      OpClrAll: valid_d = '0;
      default: ;
    endcase
    if (!cmd_i.commit) begin
      we = 1'b0;
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      nid_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmd_i.commit && (op_q == OpSetOne || op_q == OpSetPer) && free_q)
        nid_q <= nid_q + 1'b1;
      if (cmd_i.commit) out_v_q <= 1'b1;
      else if (cmd_i.out_take) out_v_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      st_q <= st_d; rid_q <= rid_d; due_q <= due_d; per_q <= per_d;
    end
  end

  assign sts_o.out_valid = out_v_q;
  assign status_o = st_q;
  assign result_id_o = rid_q;
  assign due_ms_o = due_q;
  assign is_periodic_o = per_q;

  `include "timer_table_scheduler_unit_assert.svh"
  `TTS_ASSERT_IMP(a_commit_free, clk_i, rst_ni, cmd_i.commit, !out_v_q || cmd_i.out_take, "commit over pending result")
  `TTS_ASSERT_IMP(a_clrall, clk_i, rst_ni, cmd_i.commit && op_q == OpClrAll, ##1 valid_q == '0, "clear all left slots")
  `TTS_ASSERT_IMP(a_full, clk_i, rst_ni, cmd_i.commit && st_d == StFull, valid_q == '1, "full flagged with free slot")
endmodule
